[rtl/rrsd_pkg.sv]
package rrsd_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned STRIDE_W  = 10;
  localparam int unsigned REM_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_MAX_HEIGHT = 64;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(40);

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = CFG_IDX_W'(1);

  // A run word of zero stands for the full 16-bit range of cells.
  localparam logic [REM_W-1:0] FULL_RUN = REM_W'(65536);

  typedef enum logic [1:0] {
    PH_WIDTH,
    PH_HEIGHT,
    PH_VALUE,
    PH_RUN
  } phase_e;

  typedef enum logic {
    ST_ACCEPT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load_width;
    logic load_height;
    logic load_value;
    logic load_run;
    logic step;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic done;
  } span_stat_t;

endpackage

[rtl/rrsd_span_alu.sv]
module rrsd_span_alu
  import rrsd_pkg::*;
#(
  parameter int unsigned ColW = 7,
  parameter int unsigned RowW = 7
) (
  input  logic [ColW-1:0]     width_i,
  input  logic [RowW-1:0]     height_i,
  input  logic [ColW-1:0]     col_i,
  input  logic [RowW-1:0]     row_i,
  input  logic [ADDR_W-1:0]   rstart_i,
  input  logic [STRIDE_W-1:0] stride_i,
  input  logic [REM_W-1:0]    remain_i,
  output logic [ADDR_W-1:0]   addr_o,
  output logic [ColW-1:0]     len_o,
  output logic [ColW-1:0]     col_o,
  output logic [RowW-1:0]     row_o,
  output logic [ADDR_W-1:0]   rstart_o,
  output logic [REM_W-1:0]    remain_o,
  output span_stat_t          stat_o
);

  logic [ColW-1:0]  avail;
  logic [ColW:0]    col_sum;
  logic [RowW-1:0]  row_inc;
  logic             wrap;
  logic             done;

  always_comb begin
    avail    = width_i - col_i;
    len_o    = (remain_i < REM_W'(avail)) ? remain_i[ColW-1:0] : avail;
    addr_o   = rstart_i + ADDR_W'(col_i);
    col_sum  = {1'b0, col_i} + {1'b0, len_o};
    wrap     = (col_sum >= {1'b0, width_i});
    row_inc  = row_i + RowW'(1);
    done     = wrap && (row_inc >= height_i);
    col_o    = wrap ? '0 : col_sum[ColW-1:0];
    row_o    = wrap ? row_inc : row_i;
    rstart_o = wrap ? (rstart_i + ADDR_W'(stride_i)) : rstart_i;
    remain_o = remain_i - REM_W'(len_o);
    stat_o.done = done;
    stat_o.last = (remain_o == '0) || done;
  end

endmodule

[rtl/rrsd_ctrl.sv]
module rrsd_ctrl
  import rrsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       hdr_empty_i,
  input  logic       run_ok_i,
  input  logic       out_free_i,
  input  span_stat_t stat_i,
  output logic       in_stall_o,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_ACCEPT);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      ST_ACCEPT: begin
        if (accept) begin
          unique case (phase_q)
            PH_WIDTH:  phase_d = PH_HEIGHT;
            PH_HEIGHT: phase_d = hdr_empty_i ? PH_WIDTH : PH_VALUE;
            PH_VALUE:  phase_d = PH_RUN;
            PH_RUN: begin
              if (run_ok_i) begin
                state_d = ST_EMIT;
              end else begin
                phase_d = PH_WIDTH;
              end
            end
            default:   phase_d = PH_WIDTH;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free_i && stat_i.last) begin
          state_d = ST_ACCEPT;
          phase_d = stat_i.done ? PH_WIDTH : PH_VALUE;
        end
      end
      default: state_d = ST_ACCEPT;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (phase_q)
      PH_WIDTH:  ctrl_o.load_width  = accept;
      PH_HEIGHT: ctrl_o.load_height = accept;
      PH_VALUE:  ctrl_o.load_value  = accept;
      PH_RUN:    ctrl_o.load_run    = accept && run_ok_i;
      default:   ctrl_o.load_width  = 1'b0;
    endcase
    ctrl_o.step = (state_q == ST_EMIT) && out_free_i;
  end

  assign in_stall_o = (state_q != ST_ACCEPT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
      phase_q <= PH_WIDTH;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

[rtl/rle_rect_span_decoder_core.sv]
// Header and value words are taken one per cycle.
// A run word is taken; if rows remain, the span unit then issues one span per
// cycle the output is free, one for each row the run touches, and the input
// stalls until the last; the first span is registered from the emit state.
// Reset clears the phase to the width header, all counters to zero,
// dest_base to 0 and row_stride to 40.
module rle_rect_span_decoder_core
  import rrsd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int unsigned ColW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned RowW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_W-1:0]    word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ADDR_W-1:0]    cell_addr_o,
  output logic [WORD_W-1:0]    cell_value_o,
  output logic [ColW-1:0]      span_len_o,
  output logic                 last_span_o,
  output logic                 blit_done_o
);

  logic [ADDR_W-1:0]   dest_base_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [ColW-1:0]     width_q;
  logic [RowW-1:0]     height_q;
  logic [ColW-1:0]     col_q;
  logic [RowW-1:0]     row_q;
  logic [ADDR_W-1:0]   rstart_q;
  logic [WORD_W-1:0]   value_q;
  logic [REM_W-1:0]    remain_q;
  logic                out_valid_q;

  logic [ColW-1:0]     width_d;
  logic [RowW-1:0]     height_d;
  logic                hdr_empty;
  logic                run_ok;
  logic                out_free;
  ctrl_t               ctrl;

  logic [ADDR_W-1:0]   alu_addr;
  logic [ColW-1:0]     alu_len;
  logic [ColW-1:0]     alu_col;
  logic [RowW-1:0]     alu_row;
  logic [ADDR_W-1:0]   alu_rstart;
  logic [REM_W-1:0]    alu_remain;
  span_stat_t          alu_stat;

  // Header words are clamped to MAX_WIDTH and MAX_HEIGHT.
  assign width_d  = (word_i > WORD_W'(MAX_WIDTH))  ? ColW'(MAX_WIDTH)  : word_i[ColW-1:0];
  assign height_d = (word_i > WORD_W'(MAX_HEIGHT)) ? RowW'(MAX_HEIGHT) : word_i[RowW-1:0];

  assign hdr_empty = (width_q == '0) || (word_i == '0);
  assign run_ok    = (width_q != '0) && (height_q != '0) && (row_q < height_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  rrsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .hdr_empty_i (hdr_empty),
    .run_ok_i    (run_ok),
    .out_free_i  (out_free),
    .stat_i      (alu_stat),
    .in_stall_o  (in_stall_o),
    .ctrl_o      (ctrl)
  );

  rrsd_span_alu #(
    .ColW (ColW),
    .RowW (RowW)
  ) u_span_alu (
    .width_i  (width_q),
    .height_i (height_q),
    .col_i    (col_q),
    .row_i    (row_q),
    .rstart_i (rstart_q),
    .stride_i (stride_q),
    .remain_i (remain_q),
    .addr_o   (alu_addr),
    .len_o    (alu_len),
    .col_o    (alu_col),
    .row_o    (alu_row),
    .rstart_o (alu_rstart),
    .remain_o (alu_remain),
    .stat_o   (alu_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_base_q <= '0;
      stride_q    <= STRIDE_RESET;
      width_q     <= '0;
      height_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      rstart_q    <= '0;
      value_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DEST_BASE:  dest_base_q <= cfg_data_i;
          CFG_ROW_STRIDE: stride_q    <= cfg_data_i[STRIDE_W-1:0];
          default:        ;
        endcase
      end
      if (ctrl.load_width) begin
        width_q <= width_d;
      end
      if (ctrl.load_height) begin
        height_q <= height_d;
        col_q    <= '0;
        row_q    <= '0;
        rstart_q <= dest_base_q;
      end
      if (ctrl.load_value) begin
        value_q <= word_i;
      end
      if (ctrl.load_run) begin
        remain_q <= (word_i == '0) ? FULL_RUN : REM_W'(word_i);
      end
      if (ctrl.step) begin
        col_q    <= alu_col;
        row_q    <= alu_row;
        rstart_q <= alu_rstart;
        remain_q <= alu_remain;
      end
      if (ctrl.step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register; it holds while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (ctrl.step) begin
      cell_addr_o  <= alu_addr;
      cell_value_o <= value_q;
      span_len_o   <= alu_len;
      last_span_o  <= alu_stat.last;
      blit_done_o  <= alu_stat.done;
    end
  end

  assign out_valid_o = out_valid_q;

  a_step_has_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |-> (remain_q != '0))
    else $error("span step issued with no cells left in the run");

  a_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |-> ((alu_len != '0) && (alu_len <= width_q)))
    else $error("span length outside one row");

  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && blit_done_o) |-> last_span_o)
    else $error("blit_done word without last_span");

  a_stall_while_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |-> in_stall_o)
    else $error("input open while spans are being issued");

endmodule
